@@ sv/spq_pkg.sv @@
// Shared constants, types and a helper function of the sorted priority queue.
package spq_pkg;

    // Store size and field widths.
    localparam int CAPACITY  = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_BITS   = 16;
    localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // Request codes.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED     = 2'd0,
        ST_REMOVED      = 2'd1,
        ST_FULL_DROP    = 2'd2,
        ST_EMPTY_REMOVE = 2'd3
    } t_status;

    // One stored entry, priority on top.
    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    // Adds two positions modulo the store size; both operands are below CAPACITY.
    function automatic logic [ADDR_BITS-1:0] wrap_add(input logic [ADDR_BITS-1:0] a,
                                                      input logic [ADDR_BITS-1:0] b);
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_BITS + 1)'(CAPACITY)) begin
            sum = sum - (ADDR_BITS + 1)'(CAPACITY);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

@@ sv/spq_if.sv @@
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [spq_pkg::PRIO_BITS-1:0] priority_req;
    logic [spq_pkg::ID_BITS-1:0]   item_id;

    modport source (output valid, output req_type, output priority_req, output item_id,
                    input ready);
    modport sink (input valid, input req_type, input priority_req, input item_id,
                  output ready);
endinterface

interface spq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [spq_pkg::ID_BITS-1:0]   out_id;
    logic [spq_pkg::PRIO_BITS-1:0] out_priority;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, output status, output out_id, output out_priority,
                    output is_empty, output is_full, input ready);
    modport sink (input valid, input status, input out_id, input out_priority,
                  input is_empty, input is_full, output ready);
endinterface

@@ sv/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: request sequencer around the entry memory.
//
// The queue holds up to CAPACITY entries in a circular buffer in one memory, front
// entry at the head pointer, sorted by falling priority with equal priorities kept in
// arrival order. A remove reads the front entry and advances the head. An insert walks
// back from the tail, moving each entry of lower priority one place on, one entry per
// cycle through the memory's single write port. An insert into an empty store, a
// dropped insert on a full store and a remove on an empty store need no memory read.
// One request is in work at a time; the finished result sits in an output register,
// and a stalled response holds the next result back until that register is taken.
// No clearing pass is needed after reset.
module sorted_priority_queue_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PLACE = 5'b00100,
        S_POP   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [spq_pkg::ADDR_BITS-1:0]   r_head, n_head;
    logic [spq_pkg::CNT_BITS-1:0]    r_count, n_count;
    logic [spq_pkg::ADDR_BITS-1:0]   r_j, n_j;
    spq_pkg::t_entry                 r_new, n_new;
    spq_pkg::t_status                r_status, n_status;
    spq_pkg::t_entry                 r_taken, n_taken;

    spq_pkg::t_status                r_out_status, n_out_status;
    spq_pkg::t_entry                 r_out_entry, n_out_entry;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_empty, n_out_empty;
    logic                            r_out_full, n_out_full;

    logic                            mem_we;
    logic [spq_pkg::ADDR_BITS-1:0]   mem_waddr;
    spq_pkg::t_entry                 mem_wdata;
    logic [spq_pkg::ADDR_BITS-1:0]   mem_raddr;
    spq_pkg::t_entry                 mem_rdata;

    // Entry memory.
    spq_ram #(
        .DEPTH (spq_pkg::CAPACITY),
        .WIDTH ($bits(spq_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.out_id       = r_out_entry.id;
    assign o_rsp.out_priority = r_out_entry.prio;
    assign o_rsp.is_empty     = r_out_empty;
    assign o_rsp.is_full      = r_out_full;

    // Request sequencing and memory access.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_j          = r_j;
        n_new        = r_new;
        n_status     = r_status;
        n_taken      = r_taken;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_empty  = r_out_empty;
        n_out_full   = r_out_full;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        mem_we       = 1'b0;
        mem_waddr    = r_head;
        mem_wdata    = r_new;
        mem_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_new.prio = i_req.priority_req;
                    n_new.id   = i_req.item_id;
                    n_taken    = '0;
                    if (i_req.req_type == spq_pkg::REQ_INSERT) begin
                        if (r_count == spq_pkg::CNT_BITS'(spq_pkg::CAPACITY)) begin
                            n_status = spq_pkg::ST_FULL_DROP;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            // Empty store: the new entry becomes the front at once.
                            mem_we         = 1'b1;
                            mem_wdata.prio = i_req.priority_req;
                            mem_wdata.id   = i_req.item_id;
                            n_count        = r_count + spq_pkg::CNT_BITS'(1);
                            n_status       = spq_pkg::ST_INSERTED;
                            n_state        = S_DONE;
                        end else begin
                            // Start the walk at the tail entry.
                            n_j       = spq_pkg::ADDR_BITS'(r_count - spq_pkg::CNT_BITS'(1));
                            mem_raddr = spq_pkg::wrap_add(r_head, n_j);
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::ST_EMPTY_REMOVE;
                            n_state  = S_DONE;
                        end else begin
                            mem_raddr = r_head;
                            n_state   = S_POP;
                        end
                    end
                end
            end

            S_SCAN: begin
                mem_we    = 1'b1;
                mem_waddr = spq_pkg::wrap_add(r_head, r_j + spq_pkg::ADDR_BITS'(1));
                if (mem_rdata.prio < r_new.prio) begin
                    // Lower priority: move it one place back and look further forward.
                    mem_wdata = mem_rdata;
                    if (r_j == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_j       = r_j - spq_pkg::ADDR_BITS'(1);
                        mem_raddr = spq_pkg::wrap_add(r_head, n_j);
                    end
                end else begin
                    // Equal or higher priority: the new entry goes right behind it.
                    mem_wdata = r_new;
                    n_count   = r_count + spq_pkg::CNT_BITS'(1);
                    n_status  = spq_pkg::ST_INSERTED;
                    n_state   = S_DONE;
                end
            end

            S_PLACE: begin
                // Every stored entry had lower priority, so the new one is the front.
                mem_we    = 1'b1;
                mem_waddr = r_head;
                mem_wdata = r_new;
                n_count   = r_count + spq_pkg::CNT_BITS'(1);
                n_status  = spq_pkg::ST_INSERTED;
                n_state   = S_DONE;
            end

            S_POP: begin
                n_taken  = mem_rdata;
                n_head   = spq_pkg::wrap_add(r_head, spq_pkg::ADDR_BITS'(1));
                n_count  = r_count - spq_pkg::CNT_BITS'(1);
                n_status = spq_pkg::ST_REMOVED;
                n_state  = S_DONE;
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_entry  = r_taken;
                    n_out_empty  = (r_count == '0);
                    n_out_full   = (r_count == spq_pkg::CNT_BITS'(spq_pkg::CAPACITY));
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_new        <= n_new;
        r_status     <= n_status;
        r_taken      <= n_taken;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_empty  <= n_out_empty;
        r_out_full   <= n_out_full;
    end

endmodule

@@ sv/spq_ram.sv @@
// Simple dual-port entry memory with one write port and a registered read port.
module spq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
